[rtl/gsm_pkg.sv]
// Package: shared types and constants of the scaled multiply-accumulate core.
`timescale 1ns / 1ps
package gsm_pkg;

	// reach of the 3-bit row and column fields
	localparam int unsigned FIELD_REACH = 8;
	// accumulator: eight 40-bit products plus a 32-bit beta term
	localparam int unsigned ACC_W = 44;

	// request types
	localparam logic [1:0] REQ_LOAD_A = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_LOAD_C = 2'd2;
	localparam logic [1:0] REQ_START  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_ROWS_M  = 3'd0;
	localparam logic [2:0] CFG_COLS_N  = 3'd1;
	localparam logic [2:0] CFG_INNER_K = 3'd2;
	localparam logic [2:0] CFG_ALPHA   = 3'd3;
	localparam logic [2:0] CFG_BETA    = 3'd4;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [2:0]        row;
		logic [2:0]        col;
		logic signed [15:0] value;
	} gsm_req_t;

	typedef struct packed {
		logic [2:0]        out_row;
		logic [2:0]        out_col;
		logic signed [15:0] out_value;
		logic              saturated;
		logic              last;
	} gsm_rsp_t;

	// control tag that travels with each MAC step
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic use_prod;
	} gsm_tag_t;

	// finished element from the MAC pipeline
	typedef struct packed {
		logic              valid;
		logic              sat;
		logic signed [15:0] value;
	} gsm_res_t;

endpackage

[rtl/gsm_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module gsm_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/gsm_mac.sv]
// MAC pipeline: alpha scaling, product, accumulation, rounding and saturation.
`timescale 1ns / 1ps
module gsm_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  gsm_pkg::gsm_tag_t  issue,
	input  logic signed [15:0] a_rdata,
	input  logic signed [15:0] b_rdata,
	input  logic signed [15:0] c_rdata,
	input  logic signed [15:0] alpha,
	input  logic signed [15:0] beta,
	output gsm_pkg::gsm_res_t  res,
	output logic               busy
);
	import gsm_pkg::*;

	gsm_tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	logic signed [31:0]      pa_s2;
	logic signed [15:0]      b_s2;
	logic signed [31:0]      bc_s2, bc_s3;
	logic signed [39:0]      prod_s3;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [23:0]      ap;
	logic [ACC_W-1:0]        acc_base;
	logic [ACC_W-1:0]        prod_ext;
	logic signed [ACC_W-9:0] q;

	// tags line up with RAM read data in the cycle after issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= issue;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// floor(alpha*A / 256)
	assign ap = pa_s2[31:8];

	assign acc_base = tag_s3.first ? {{(ACC_W-32){bc_s3[31]}}, bc_s3} : acc_q;
	assign prod_ext = {{(ACC_W-40){prod_s3[39]}}, prod_s3};

	// datapath registers
	always_ff @(posedge clk) begin
		pa_s2 <= alpha * a_rdata;
		b_s2  <= b_rdata;
		bc_s2 <= beta * c_rdata;
		bc_s3 <= bc_s2;
		if (tag_s2.use_prod) begin
			prod_s3 <= ap * b_s2;
		end else begin
			prod_s3 <= '0;
		end
		if (tag_s3.valid) begin
			acc_q <= acc_base + prod_ext;
		end
	end

	// floor(acc / 256) then clip to 16 bits
	assign q = acc_q[ACC_W-1:8];

	always_comb begin
		res.valid = tag_s4.valid && tag_s4.last;
		if (q > $signed(36'd32767)) begin
			res.value = 16'sh7fff;
			res.sat   = 1'b1;
		end else if (q < -$signed(36'd32768)) begin
			res.value = 16'sh8000;
			res.sat   = 1'b1;
		end else begin
			res.value = q[15:0];
			res.sat   = 1'b0;
		end
	end

	assign busy = tag_s1.valid || tag_s2.valid || tag_s3.valid || tag_s4.valid;

endmodule

[rtl/gemm_scaled_multiply_accumulate_core.sv]
// Top level: request decode, element sequencer, matrix stores and result register.
// Load beats are taken only while idle and emit nothing.
// A start beat emits M*N results (dimensions clamped to the store size); each element
// issues one A/B read pair per cycle, its first waiting for a free result register,
// then waits for the four-stage MAC pipeline to drain.
// Reset clears control state and config (M=N=K=8, alpha=1.0, beta=0); store
// contents are undefined until loaded.
`timescale 1ns / 1ps
module gemm_scaled_multiply_accumulate_core #(
	parameter int unsigned MAX_DIM = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  gsm_pkg::gsm_req_t req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output gsm_pkg::gsm_rsp_t rsp_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_wdata
);
	import gsm_pkg::*;

	localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LIMIT = (MAX_DIM < FIELD_REACH) ? MAX_DIM : FIELD_REACH;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	logic [1:0] state_q;
	logic [3:0] rows_q, cols_q, inner_q;
	logic signed [15:0] alpha_q, beta_q;
	logic [3:0] m_q, n_q, kd_q;
	logic [2:0] i_q, j_q, k_q;
	logic       rsp_valid_q;
	gsm_rsp_t   rsp_q;

	logic       req_beat, ld_beat, ld_ok, start_beat;
	logic [3:0] m_eff, n_eff, k_eff;
	logic [AW-1:0] ld_addr, a_raddr, b_raddr, c_addr, c_waddr;
	logic signed [15:0] a_rdata, b_rdata, c_rdata, c_wdata;
	logic       out_free, issue_en, step_last, elem_last;
	gsm_tag_t   issue;
	gsm_res_t   res;
	logic       mac_busy;

	// request decode
	assign req_stall  = (state_q != ST_IDLE);
	assign req_beat   = req_valid && !req_stall;
	assign start_beat = req_beat && (req_data.req_type == REQ_START);
	assign ld_ok      = (32'(req_data.row) < MAX_DIM) && (32'(req_data.col) < MAX_DIM);
	assign ld_beat    = req_beat && (req_data.req_type != REQ_START) && ld_ok;
	assign ld_addr    = AW'(32'(req_data.row) * MAX_DIM + 32'(req_data.col));

	// dimensions clamped to what the stores and fields reach
	assign m_eff = (32'(rows_q) > LIMIT) ? 4'(LIMIT) : rows_q;
	assign n_eff = (32'(cols_q) > LIMIT) ? 4'(LIMIT) : cols_q;
	assign k_eff = (32'(inner_q) > LIMIT) ? 4'(LIMIT) : inner_q;

	// store addressing
	assign a_raddr = AW'(32'(i_q) * MAX_DIM + 32'(k_q));
	assign b_raddr = AW'(32'(k_q) * MAX_DIM + 32'(j_q));
	assign c_addr  = AW'(32'(i_q) * MAX_DIM + 32'(j_q));
	assign c_waddr = res.valid ? c_addr : ld_addr;
	assign c_wdata = res.valid ? res.value : req_data.value;

	gsm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_a_store (
		.clk   (clk),
		.we    (ld_beat && (req_data.req_type == REQ_LOAD_A)),
		.waddr (ld_addr),
		.wdata (req_data.value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	gsm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_b_store (
		.clk   (clk),
		.we    (ld_beat && (req_data.req_type == REQ_LOAD_B)),
		.waddr (ld_addr),
		.wdata (req_data.value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	gsm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_c_store (
		.clk   (clk),
		.we    (res.valid || (ld_beat && (req_data.req_type == REQ_LOAD_C))),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_addr),
		.rdata (c_rdata)
	);

	// issue control: first step of an element waits for a free result register
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign issue_en  = (state_q == ST_ISSUE) && ((k_q != 3'd0) || out_free);
	assign step_last = (kd_q == 4'd0) || (({1'b0, k_q} + 4'd1) == kd_q);
	assign elem_last = (({1'b0, i_q} + 4'd1) == m_q) && (({1'b0, j_q} + 4'd1) == n_q);

	assign issue.valid    = issue_en;
	assign issue.first    = (k_q == 3'd0);
	assign issue.last     = step_last;
	assign issue.use_prod = (kd_q != 4'd0);

	gsm_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (issue),
		.a_rdata (a_rdata),
		.b_rdata (b_rdata),
		.c_rdata (c_rdata),
		.alpha   (alpha_q),
		.beta    (beta_q),
		.res     (res),
		.busy    (mac_busy)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= 4'd8;
			cols_q  <= 4'd8;
			inner_q <= 4'd8;
			alpha_q <= 16'sd256;
			beta_q  <= 16'sd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS_M:  rows_q  <= cfg_wdata[3:0];
				CFG_COLS_N:  cols_q  <= cfg_wdata[3:0];
				CFG_INNER_K: inner_q <= cfg_wdata[3:0];
				CFG_ALPHA:   alpha_q <= cfg_wdata;
				CFG_BETA:    beta_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// element sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_q     <= '0;
			n_q     <= '0;
			kd_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start_beat && (m_eff != 4'd0) && (n_eff != 4'd0)) begin
						m_q     <= m_eff;
						n_q     <= n_eff;
						kd_q    <= k_eff;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (issue_en) begin
						if (step_last) begin
							k_q     <= '0;
							state_q <= ST_WAIT;
						end else begin
							k_q <= k_q + 3'd1;
						end
					end
				end
				ST_WAIT: begin
					if (!mac_busy) begin
						if (elem_last) begin
							state_q <= ST_IDLE;
						end else begin
							if (({1'b0, j_q} + 4'd1) == n_q) begin
								j_q <= '0;
								i_q <= i_q + 3'd1;
							end else begin
								j_q <= j_q + 3'd1;
							end
							state_q <= ST_ISSUE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			rsp_q.out_row   <= i_q;
			rsp_q.out_col   <= j_q;
			rsp_q.out_value <= res.value;
			rsp_q.saturated <= res.sat;
			rsp_q.last      <= elem_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// a finished element never lands on a result still waiting
	a_res_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result overwrote a pending beat");

	// pipeline holds nothing while requests are taken
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mac_busy)
		else $error("MAC pipeline active while idle");

	// results finish only while the sequencer waits on the drain
	a_res_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == ST_WAIT))
		else $error("result finished outside drain");

	// a new output beat comes only from a finished element
	a_rsp_from_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(res.valid))
		else $error("output valid without a finished element");

endmodule
